// ===== sv/ps2_mouse_packet_tracker_assert.svh =====
// assertion macros for the ps2 mouse packet tracker
`ifndef PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PMT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ps2mpt_pkg.sv =====
package ps2mpt_pkg;

  localparam int POS_W = 10;
  localparam int REG_W = 10;
  localparam int BYTE_W = 8;
  localparam int BTN_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam int EXT_W = (POS_W > REG_W) ? POS_W : REG_W;
  localparam int SUM_W = EXT_W + 2;

  localparam int OUT_W = 2 * POS_W + BTN_W;
  localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic [BYTE_W-1:0] SYNC_MASK = 8'h08;
  localparam logic [BYTE_W-1:0] BUTTON_MASK = 8'h07;

  localparam logic [REG_W-1:0] WIDTH_RESET = 10'd160;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 10'd80;

  localparam logic [CFG_IDX_W-1:0] REG_X_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE = 2'd1;

  // cur + delta, clamped to 0 .. min(size-1, POS_MAX); size 0 acts as 1
  function automatic logic [POS_W-1:0] clamp_pos(
    input logic [POS_W-1:0] cur,
    input logic signed [8:0] delta,
    input logic [REG_W-1:0] size
  );
    logic signed [SUM_W-1:0] v;
    logic [EXT_W-1:0] hi;
    logic [POS_W-1:0] res;
    v = signed'(SUM_W'(cur)) + SUM_W'(delta);
    if (size == '0) begin
      hi = '0;
    end else begin
      hi = EXT_W'(size) - EXT_W'(1);
    end
    if (hi > EXT_W'(POS_MAX)) begin
      hi = EXT_W'(POS_MAX);
    end
    if (v < 0) begin
      res = '0;
    end else if (v > signed'(SUM_W'(hi))) begin
      res = hi[POS_W-1:0];
    end else begin
      res = v[POS_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/ps2_mouse_packet_tracker.sv =====
// Three-byte mouse packet decoder with a clamped cursor. Bytes enter on the
// s_axis port; a first byte without bit 3 set is dropped to realign. Every
// third byte of a packet yields one m_axis transfer with the new position and
// the header's three button bits. One byte is taken per cycle while no byte
// is held back by a full output register: a byte is registered on entry and
// then processed into the result register that drives m_axis. Only a packet's
// last byte waits on a result still held in the output register; other bytes
// keep flowing. The user must write the X and Y size registers through the
// cfg port only while the block is idle; the block does not enforce this.
module ps2_mouse_packet_tracker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ps2mpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ps2mpt_pkg::REG_W-1:0]          cfg_data,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [ps2mpt_pkg::BYTE_W-1:0]         s_axis_tdata,  // data_byte
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [ps2mpt_pkg::M_TDATA_W-1:0]      m_axis_tdata   // pos_x, pos_y, button_bits
);

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_DX   = 2'd1,
    PH_DY   = 2'd2
  } phase_t;

  logic [ps2mpt_pkg::REG_W-1:0]  x_size;
  logic [ps2mpt_pkg::REG_W-1:0]  y_size;

  logic                          in_valid;
  logic [ps2mpt_pkg::BYTE_W-1:0] in_byte;

  phase_t                        phase;
  logic [ps2mpt_pkg::BYTE_W-1:0] header_byte;
  logic [ps2mpt_pkg::BYTE_W-1:0] delta_x_byte;
  logic [ps2mpt_pkg::POS_W-1:0]  cursor_x;
  logic [ps2mpt_pkg::POS_W-1:0]  cursor_y;

  logic [ps2mpt_pkg::POS_W-1:0]  pos_x;
  logic [ps2mpt_pkg::POS_W-1:0]  pos_y;
  logic [ps2mpt_pkg::BTN_W-1:0]  button_bits;

  logic                          out_free;
  logic                          advance;
  logic [ps2mpt_pkg::POS_W-1:0]  cursor_x_next;
  logic [ps2mpt_pkg::POS_W-1:0]  cursor_y_next;
  logic signed [8:0]             dx;
  logic signed [8:0]             dy_neg;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign advance = in_valid && ((phase != PH_DY) || out_free);
  assign s_axis_tready = !in_valid || advance;

  assign dx = signed'({delta_x_byte[7], delta_x_byte});
  assign dy_neg = -signed'({in_byte[7], in_byte});
  assign cursor_x_next = ps2mpt_pkg::clamp_pos(cursor_x, dx, x_size);
  assign cursor_y_next = ps2mpt_pkg::clamp_pos(cursor_y, dy_neg, y_size);

  assign m_axis_tdata = ps2mpt_pkg::M_TDATA_W'({button_bits, pos_y, pos_x});

  always_ff @(posedge clk) begin
    if (rst) begin
      x_size <= ps2mpt_pkg::WIDTH_RESET;
      y_size <= ps2mpt_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == ps2mpt_pkg::REG_X_SIZE) begin
        x_size <= cfg_data;
      end else if (cfg_index == ps2mpt_pkg::REG_Y_SIZE) begin
        y_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEAD;
      cursor_x <= '0;
      cursor_y <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (advance) begin
        unique case (phase)
          PH_DX: begin
            delta_x_byte <= in_byte;
            phase <= PH_DY;
          end
          PH_DY: begin
            cursor_x <= cursor_x_next;
            cursor_y <= cursor_y_next;
            pos_x <= cursor_x_next;
            pos_y <= cursor_y_next;
            button_bits <= ps2mpt_pkg::BTN_W'(header_byte & ps2mpt_pkg::BUTTON_MASK);
            m_axis_tvalid <= 1'b1;
            phase <= PH_HEAD;
          end
          default: begin
            // header slot; unused code also lands here
            if ((in_byte & ps2mpt_pkg::SYNC_MASK) != '0) begin
              header_byte <= in_byte;
              phase <= PH_DX;
            end else begin
              phase <= PH_HEAD;
            end
          end
        endcase
      end
    end
  end

`include "ps2_mouse_packet_tracker_assert.svh"

  `PMT_ASSERT_NEXT(a_dy_makes_result, advance && (phase == PH_DY), m_axis_tvalid, "no result after last byte")
  `PMT_ASSERT_IMPL(a_header_synced, (phase == PH_DX) || (phase == PH_DY), header_byte[3], "header lacks sync bit")
  `PMT_ASSERT_NEXT(a_in_hold, in_valid && !advance, in_valid && $stable(in_byte), "held byte lost")

endmodule
